/* design/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, codes and constants for the console/frame stream splitter.
// ----------------------------------------------------------------------------
package cfd_pkg;

   // Input item: a received byte or a millisecond tick
   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
   } req_type;

   // Result item
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [15:0] sequence_res;
      logic [15:0] rejected_total;
      logic        last;
   } rsp_type;

   // One queue entry holds every result of one input item
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    pair;
   } q_entry_type;

   // Queue status from the queue to front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      KIND_CHAR           = 3'd0,
      KIND_LINE_END       = 3'd1,
      KIND_FRAME_BYTE     = 3'd2,
      KIND_FRAME_END      = 3'd3,
      KIND_VERSION_REJECT = 3'd4,
      KIND_LENGTH_REJECT  = 3'd5,
      KIND_TIMEOUT        = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      PH_CONSOLE = 2'd0,
      PH_HELD_C  = 2'd1,
      PH_FRAME   = 2'd2
   } phase_type;

   typedef enum logic [7:0] {
      CSR_FRAME_TIMEOUT = 8'd0,
      CSR_PROTO_VERSION = 8'd1,
      CSR_MAX_PAYLOAD   = 8'd2,
      CSR_LINE_LIMIT    = 8'd3
   } csr_index_type;

   localparam logic [7:0]  CHAR_C   = 8'h43;
   localparam logic [7:0]  CHAR_D   = 8'h44;
   localparam logic [7:0]  CHAR_CR  = 8'h0d;
   localparam logic [7:0]  CHAR_LF  = 8'h0a;
   localparam logic [7:0]  PRINT_LO = 8'h20;
   localparam logic [7:0]  PRINT_HI = 8'h7e;

   localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd2000;
   localparam logic [7:0]  RST_PROTO_VERSION = 8'd2;
   localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd4096;
   localparam logic [7:0]  RST_LINE_LIMIT    = 8'd180;

   localparam int          CNT_W      = 17;
   localparam logic [16:0] HEADER_LEN = 17'd8;
   localparam logic [16:0] FRAME_OPEN_CNT = 17'd2;
   localparam int          HDR_BYTES  = 5;
   localparam int          HDR_FIRST  = 2;

   localparam int          QUEUE_DEPTH = 4;
   localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Outcome of one console byte
   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
      logic [7:0] len;
   } cons_type;

   function automatic cons_type cons_step(input logic [7:0] b,
                                          input logic [7:0] len,
                                          input logic [7:0] limit);
      cons_type r;
      r.hit  = 1'b0;
      r.kind = KIND_CHAR;
      r.len  = len;
      if (b == CHAR_LF) begin
         r.hit  = 1'b1;
         r.kind = KIND_LINE_END;
         r.len  = 8'd0;
      end else if (b != CHAR_CR && (b inside {[PRINT_LO:PRINT_HI]}) && len < limit) begin
         r.hit  = 1'b1;
         r.kind = KIND_CHAR;
         r.len  = len + 8'd1;
      end
      return r;
   endfunction

endpackage

/* design/cfd_queue.sv */
// ----------------------------------------------------------------------------
// cfd_queue
// Short queue of result entries between the classifier and the output stage.
// ----------------------------------------------------------------------------
module cfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cfd_pkg::q_entry_type  push_entry,
   input  logic                  pop,
   output cfd_pkg::q_entry_type  head_entry,
   output cfd_pkg::q_status_type status
);

   cfd_pkg::q_entry_type              entries_ff [cfd_pkg::QUEUE_DEPTH];
   logic [cfd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cfd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cfd_pkg::QCNT_W-1:0]        count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cfd_pkg::QPTR_W'(cfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cfd_pkg::QPTR_W'(cfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* design/cfd_front.sv */
// ----------------------------------------------------------------------------
// cfd_front
// Accept items, track console/frame phase, check headers and build results.
// ----------------------------------------------------------------------------
module cfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cfd_pkg::req_type     req,
   input  logic                 csr_write,
   input  logic [7:0]           csr_index,
   input  logic [15:0]          csr_data,
   output logic                 push,
   output cfd_pkg::q_entry_type push_entry
);

   // Configuration registers
   logic [15:0] timeout_cfg_ff;
   logic [7:0]  version_cfg_ff;
   logic [15:0] max_payload_cfg_ff;
   logic [7:0]  line_limit_cfg_ff;

   // Stream state
   cfd_pkg::phase_type          phase_ff, phase_in;
   logic [7:0]                  line_len_ff, line_len_in;
   logic [cfd_pkg::CNT_W-1:0]   frame_cnt_ff, frame_cnt_in;
   logic [cfd_pkg::CNT_W-1:0]   exp_len_ff, exp_len_in;
   logic [15:0]                 tmo_cnt_ff, tmo_cnt_in;
   logic [15:0]                 rej_cnt_ff, rej_cnt_in;
   logic [7:0]                  hdr_ff [cfd_pkg::HDR_BYTES];

   // Classification
   logic                        is_tick;
   logic [7:0]                  b;
   logic [15:0]                 tmo_inc;
   logic [15:0]                 payload;
   logic [cfd_pkg::CNT_W-1:0]   cnt_next;
   logic [cfd_pkg::CNT_W-1:0]   exp_eff;
   logic                        ev_timeout, ev_hold, ev_open, ev_replay, ev_cons;
   logic                        in_frame, hdr_done, ev_ver, ev_len, ev_done;
   logic                        ev_reject, ev_exit;
   cfd_pkg::cons_type           c1, c2;
   cfd_pkg::rsp_type            res0, res1;
   logic [1:0]                  n_res;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_cfg_ff     <= cfd_pkg::RST_FRAME_TIMEOUT;
         version_cfg_ff     <= cfd_pkg::RST_PROTO_VERSION;
         max_payload_cfg_ff <= cfd_pkg::RST_MAX_PAYLOAD;
         line_limit_cfg_ff  <= cfd_pkg::RST_LINE_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            cfd_pkg::CSR_FRAME_TIMEOUT: timeout_cfg_ff     <= csr_data;
            cfd_pkg::CSR_PROTO_VERSION: version_cfg_ff     <= csr_data[7:0];
            cfd_pkg::CSR_MAX_PAYLOAD:   max_payload_cfg_ff <= csr_data;
            cfd_pkg::CSR_LINE_LIMIT:    line_limit_cfg_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Classify the item
   always_comb begin
      is_tick  = req.mode;
      b        = req.byte_value;
      tmo_inc  = (tmo_cnt_ff == '1) ? tmo_cnt_ff : tmo_cnt_ff + 16'd1;
      payload  = {b, hdr_ff[4]};
      cnt_next = frame_cnt_ff + 1'b1;

      ev_timeout = is_tick && (phase_ff != cfd_pkg::PH_CONSOLE) &&
                   (tmo_inc >= timeout_cfg_ff);
      ev_hold    = !is_tick && (phase_ff == cfd_pkg::PH_CONSOLE) &&
                   (line_len_ff == 8'd0) && (b == cfd_pkg::CHAR_C);
      ev_cons    = !is_tick && (phase_ff == cfd_pkg::PH_CONSOLE) && !ev_hold;
      ev_open    = !is_tick && (phase_ff == cfd_pkg::PH_HELD_C) && (b == cfd_pkg::CHAR_D);
      ev_replay  = !is_tick && (phase_ff == cfd_pkg::PH_HELD_C) && (b != cfd_pkg::CHAR_D);
      in_frame   = !is_tick && (phase_ff == cfd_pkg::PH_FRAME);

      hdr_done = in_frame && (cnt_next == cfd_pkg::HEADER_LEN);
      ev_ver   = hdr_done && (hdr_ff[0] != version_cfg_ff);
      ev_len   = hdr_done && !ev_ver && (payload > max_payload_cfg_ff);
      exp_eff  = hdr_done ? cfd_pkg::HEADER_LEN + {1'b0, payload} : exp_len_ff;
      ev_done  = in_frame && !ev_ver && !ev_len && (exp_eff != '0) &&
                 (cnt_next == exp_eff);

      ev_reject = ev_timeout || ev_ver || ev_len;
      ev_exit   = ev_reject || ev_done;

      // Held 'C' is replayed first, then the new byte
      c1 = cfd_pkg::cons_step(ev_replay ? cfd_pkg::CHAR_C : b, line_len_ff,
                              line_limit_cfg_ff);
      c2 = cfd_pkg::cons_step(b, c1.len, line_limit_cfg_ff);
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (ev_exit || ev_replay) begin
            phase_in = cfd_pkg::PH_CONSOLE;
         end else if (ev_hold) begin
            phase_in = cfd_pkg::PH_HELD_C;
         end else if (ev_open) begin
            phase_in = cfd_pkg::PH_FRAME;
         end
      end
   end

   // Counters and results
   always_comb begin
      line_len_in  = line_len_ff;
      frame_cnt_in = frame_cnt_ff;
      exp_len_in   = exp_len_ff;
      tmo_cnt_in   = tmo_cnt_ff;
      rej_cnt_in   = rej_cnt_ff;
      res0         = '0;
      res1         = '0;
      n_res        = 2'd0;

      if (ev_reject && rej_cnt_ff != '1) begin
         rej_cnt_in = rej_cnt_ff + 16'd1;
      end
      if (ev_cons) begin
         line_len_in = c1.len;
      end else if (ev_replay) begin
         line_len_in = c2.len;
      end
      if (ev_hold) begin
         tmo_cnt_in = '0;
      end else if (is_tick && phase_ff != cfd_pkg::PH_CONSOLE) begin
         tmo_cnt_in = tmo_inc;
      end
      if (ev_exit || ev_open) begin
         exp_len_in = '0;
      end else if (hdr_done) begin
         exp_len_in = exp_eff;
      end
      if (ev_exit) begin
         frame_cnt_in = '0;
      end else if (ev_open) begin
         frame_cnt_in = cfd_pkg::FRAME_OPEN_CNT;
      end else if (in_frame) begin
         frame_cnt_in = cnt_next;
      end

      // Build result items
      if (ev_timeout) begin
         res0.kind = cfd_pkg::KIND_TIMEOUT;
         n_res     = 2'd1;
      end else if (ev_ver) begin
         res0.kind = cfd_pkg::KIND_VERSION_REJECT;
         n_res     = 2'd1;
      end else if (ev_len) begin
         res0.kind         = cfd_pkg::KIND_LENGTH_REJECT;
         res0.frame_type   = hdr_ff[1];
         res0.sequence_res = {hdr_ff[3], hdr_ff[2]};
         n_res             = 2'd1;
      end else if (in_frame) begin
         res0.kind      = ev_done ? cfd_pkg::KIND_FRAME_END : cfd_pkg::KIND_FRAME_BYTE;
         res0.data_byte = b;
         n_res          = 2'd1;
      end else if (ev_open) begin
         res0.kind      = cfd_pkg::KIND_FRAME_BYTE;
         res0.data_byte = cfd_pkg::CHAR_C;
         res1.kind      = cfd_pkg::KIND_FRAME_BYTE;
         res1.data_byte = cfd_pkg::CHAR_D;
         n_res          = 2'd2;
      end else if (ev_cons && c1.hit) begin
         res0.kind      = c1.kind;
         res0.data_byte = (c1.kind == cfd_pkg::KIND_CHAR) ? b : 8'd0;
         n_res          = 2'd1;
      end else if (ev_replay) begin
         if (c1.hit) begin
            res0.kind      = c1.kind;
            res0.data_byte = cfd_pkg::CHAR_C;
            n_res          = 2'd1;
            if (c2.hit) begin
               res1.kind      = c2.kind;
               res1.data_byte = (c2.kind == cfd_pkg::KIND_CHAR) ? b : 8'd0;
               n_res          = 2'd2;
            end
         end else if (c2.hit) begin
            res0.kind      = c2.kind;
            res0.data_byte = (c2.kind == cfd_pkg::KIND_CHAR) ? b : 8'd0;
            n_res          = 2'd1;
         end
      end

      res0.rejected_total = rej_cnt_in;
      res1.rejected_total = rej_cnt_in;
      res0.last           = (n_res != 2'd2);
      res1.last           = 1'b1;
   end

   assign push              = accept && (n_res != 2'd0);
   assign push_entry.first  = res0;
   assign push_entry.second = res1;
   assign push_entry.pair   = (n_res == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfd_pkg::PH_CONSOLE;
         line_len_ff  <= '0;
         frame_cnt_ff <= '0;
         exp_len_ff   <= '0;
         tmo_cnt_ff   <= '0;
         rej_cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            line_len_ff  <= line_len_in;
            frame_cnt_ff <= frame_cnt_in;
            exp_len_ff   <= exp_len_in;
            tmo_cnt_ff   <= tmo_cnt_in;
            rej_cnt_ff   <= rej_cnt_in;
         end
      end
   end

   // Capture header bytes 2 to 6
   always_ff @(posedge clock) begin
      for (int i = 0; i < cfd_pkg::HDR_BYTES; i++) begin
         if (accept && in_frame &&
             frame_cnt_ff == cfd_pkg::CNT_W'(i + cfd_pkg::HDR_FIRST)) begin
            hdr_ff[i] <= b;
         end
      end
   end

endmodule

/* design/cfd_back.sv */
// ----------------------------------------------------------------------------
// cfd_back
// Present queued results one item at a time and release finished entries.
// ----------------------------------------------------------------------------
module cfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cfd_pkg::q_entry_type  head_entry,
   input  cfd_pkg::q_status_type status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfd_pkg::rsp_type      rsp_data
);

   logic sel_ff, sel_in;
   logic take;

   // Select the current result of the head entry
   assign rsp_valid = !status.empty;
   assign rsp_data  = sel_ff ? head_entry.second : head_entry.first;
   assign take      = rsp_valid && !rsp_stall;
   assign pop       = take && (sel_ff || !head_entry.pair);

   // Advance to the second result, back to the first after the last
   always_comb begin
      sel_in = sel_ff;
      if (take) begin
         sel_in = !sel_ff && head_entry.pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

/* design/console_frame_demux.sv */
// ----------------------------------------------------------------------------
// console_frame_demux
// Split a serial byte stream into console text and checked binary frames.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (mode, byte_value)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (kind ... last)
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// The front takes one item per cycle while the queue is not full; its state
// update finishes in that cycle. An item's results leave one at a time; a
// four-entry queue between classifier and output absorbs that and any output
// stall. req_stall rises only when the queue is full. csr_ready stays high.
// Reset is synchronous; it restores all but queue entries and header bytes.
// ----------------------------------------------------------------------------
module console_frame_demux (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfd_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data
);

   cfd_pkg::q_status_type q_status;
   cfd_pkg::q_entry_type  push_entry;
   cfd_pkg::q_entry_type  head_entry;
   logic                  push;
   logic                  pop;
   logic                  req_accept;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   cfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_data),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_entry (push_entry)
   );

   cfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   cfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .status     (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
